@@ hw/rtl/pbq_pkg.sv @@
// Shared types, constants and small helper functions of the point batch quantizer.
// Used by pbq_bounds, pbq_div and point_batch_quantizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pbq_pkg;

    localparam int COORD_W   = 32;
    localparam int CODE_BITS = 30;
    localparam int PLANE_W   = 10;
    localparam int COLOR_W   = 24;
    localparam int TOTAL_W   = 11;
    localparam int CHAN_W    = 16;

    localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic FUNC_BOUND  = 1'b0;
    localparam logic FUNC_ENCODE = 1'b1;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_DESC  = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } axes_t;

    typedef struct packed {
        axes_t low;
        axes_t high;
    } box_t;

    // 16-bit channel to 8 bits: keep small values, otherwise take the high byte
    function automatic logic [7:0] reduce_channel(input logic [CHAN_W-1:0] c);
        logic [7:0] r;
        if (c[15:8] == 8'd0) begin
            r = c[7:0];
        end else begin
            r = c[15:8];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/point_batch_quantizer.sv @@
// Top level of the point batch quantizer: handshake, sequencer, output register.
// Instantiates pbq_bounds and three pbq_div units; depends on pbq_pkg.
//
//   channel | ports   | direction | beat carries
//   --------+---------+-----------+---------------------------------------------
//   input   | s_*     | in        | pass select, raw x/y/z, 16-bit color, last
//   result  | m_*     | out       | point codes and color, or batch descriptor
//
// A bound beat without last leaves the input ready. A bound beat marked last moves to the
// emit state, which loads the descriptor into the output register once it is free; the
// input waits until then. An encode beat holds the input: the accepting edge loads the
// per-axis differences, the prepare state classifies the range, the 30 divider steps shift
// in one quotient bit per axis, and the emit state loads the output register once free.
// Reset (aresetn low, synchronous) empties the output register and sets the box to its
// empty state. A stalled result waits in the output register while the next beat is taken;
// a finished result waits in the core, input blocked, until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module point_batch_quantizer #(
    parameter int BATCH_POINTS = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_func,
    input  wire logic signed [pbq_pkg::COORD_W-1:0] s_raw_x,
    input  wire logic signed [pbq_pkg::COORD_W-1:0] s_raw_y,
    input  wire logic signed [pbq_pkg::COORD_W-1:0] s_raw_z,
    input  wire logic [pbq_pkg::CHAN_W-1:0]         s_red_in,
    input  wire logic [pbq_pkg::CHAN_W-1:0]         s_green_in,
    input  wire logic [pbq_pkg::CHAN_W-1:0]         s_blue_in,
    input  wire logic                               s_last,

    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic                                    m_kind,
    output logic [pbq_pkg::CODE_BITS-1:0]           m_code_coarse,
    output logic [pbq_pkg::CODE_BITS-1:0]           m_code_mid,
    output logic [pbq_pkg::CODE_BITS-1:0]           m_code_fine,
    output logic [pbq_pkg::COLOR_W-1:0]             m_color,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_min_x,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_min_y,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_min_z,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_max_x,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_max_y,
    output logic signed [pbq_pkg::COORD_W-1:0]      m_max_z,
    output logic [pbq_pkg::TOTAL_W-1:0]             m_point_total
);

    localparam int STEP_W = $clog2(pbq_pkg::CODE_BITS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(pbq_pkg::CODE_BITS - 1);
    localparam int PW = pbq_pkg::PLANE_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_STEP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic                          accept, bound_acc, encode_acc;
    logic                          out_free, out_load;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic                          kind_reg, kind_next;
    logic [pbq_pkg::COLOR_W-1:0]   color_reg;
    logic                          m_valid_reg, m_valid_next;

    pbq_pkg::axes_t                pt;
    pbq_pkg::box_t                 box;
    logic [pbq_pkg::TOTAL_W-1:0]   total;
    logic [pbq_pkg::CODE_BITS-1:0] qx, qy, qz;

    assign accept     = s_valid && s_ready;
    assign bound_acc  = accept && (s_func == pbq_pkg::FUNC_BOUND);
    assign encode_acc = accept && (s_func == pbq_pkg::FUNC_ENCODE);
    assign pt         = '{s_raw_x, s_raw_y, s_raw_z};

    pbq_bounds #(
        .BATCH_POINTS(BATCH_POINTS)
    ) u_bounds (
        .aclk   (aclk),
        .aresetn(aresetn),
        .upd    (bound_acc),
        .last   (s_last),
        .pt     (pt),
        .box    (box),
        .total  (total)
    );

    // Encode uses whatever box is held, finished or still open.
    pbq_div u_div_x (
        .aclk(aclk), .load(encode_acc), .prep(state_reg == ST_PREP),
        .step(state_reg == ST_STEP), .v(s_raw_x), .lo(box.low.x), .hi(box.high.x),
        .code(qx)
    );

    pbq_div u_div_y (
        .aclk(aclk), .load(encode_acc), .prep(state_reg == ST_PREP),
        .step(state_reg == ST_STEP), .v(s_raw_y), .lo(box.low.y), .hi(box.high.y),
        .code(qy)
    );

    pbq_div u_div_z (
        .aclk(aclk), .load(encode_acc), .prep(state_reg == ST_PREP),
        .step(state_reg == ST_STEP), .v(s_raw_z), .lo(box.low.z), .hi(box.high.z),
        .code(qz)
    );

    // Output register is free when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == ST_EMIT) && out_free;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (encode_acc) begin
                    kind_next  = pbq_pkg::KIND_POINT;
                    state_next = ST_PREP;
                end else if (bound_acc && s_last) begin
                    // descriptor reads the box once it has taken this beat
                    kind_next  = pbq_pkg::KIND_DESC;
                    state_next = ST_EMIT;
                end
            end
            ST_PREP: begin
                step_next  = '0;
                state_next = ST_STEP;
            end
            ST_STEP: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Sequencer payload: step count, result kind, reduced color.
    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        kind_reg <= kind_next;
        if (encode_acc) begin
            color_reg <= {pbq_pkg::reduce_channel(s_blue_in),
                          pbq_pkg::reduce_channel(s_green_in),
                          pbq_pkg::reduce_channel(s_red_in)};
        end
    end

    // Output register: load the finished result, zero the fields it does not use.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind <= kind_reg;
            if (kind_reg == pbq_pkg::KIND_DESC) begin
                m_code_coarse <= '0;
                m_code_mid    <= '0;
                m_code_fine   <= '0;
                m_color       <= '0;
                m_min_x       <= box.low.x;
                m_min_y       <= box.low.y;
                m_min_z       <= box.low.z;
                m_max_x       <= box.high.x;
                m_max_y       <= box.high.y;
                m_max_z       <= box.high.z;
                m_point_total <= total;
            end else begin
                m_code_coarse <= {qz[3*PW-1:2*PW], qy[3*PW-1:2*PW], qx[3*PW-1:2*PW]};
                m_code_mid    <= {qz[2*PW-1:PW], qy[2*PW-1:PW], qx[2*PW-1:PW]};
                m_code_fine   <= {qz[PW-1:0], qy[PW-1:0], qx[PW-1:0]};
                m_color       <= color_reg;
                m_min_x       <= '0;
                m_min_y       <= '0;
                m_min_z       <= '0;
                m_max_x       <= '0;
                m_max_y       <= '0;
                m_max_z       <= '0;
                m_point_total <= '0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ hw/rtl/pbq_bounds.sv @@
// Bounding box tracker: per-axis minimum and maximum plus saturating point count.
// Depends on pbq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbq_bounds #(
    parameter int BATCH_POINTS = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          upd,
    input  wire logic                          last,
    input  wire pbq_pkg::axes_t                pt,
    output pbq_pkg::box_t                      box,
    output logic [pbq_pkg::TOTAL_W-1:0]        total
);

    localparam int CNT_W = $clog2(BATCH_POINTS + 1);
    localparam logic [CNT_W-1:0] BATCH_CNT = CNT_W'(BATCH_POINTS);

    pbq_pkg::box_t    box_reg, box_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             closed_reg, closed_next;
    logic [CNT_W+pbq_pkg::TOTAL_W-1:0] cnt_wide;

    always_comb begin
        box_next    = box_reg;
        cnt_next    = cnt_reg;
        closed_next = closed_reg;
        if (upd) begin
            if (closed_reg) begin
                // first point of a new pass replaces the old box
                box_next.low  = pt;
                box_next.high = pt;
                cnt_next      = CNT_W'(1);
            end else begin
                if ($signed(pt.x) < $signed(box_reg.low.x))  box_next.low.x  = pt.x;
                if ($signed(pt.y) < $signed(box_reg.low.y))  box_next.low.y  = pt.y;
                if ($signed(pt.z) < $signed(box_reg.low.z))  box_next.low.z  = pt.z;
                if ($signed(pt.x) > $signed(box_reg.high.x)) box_next.high.x = pt.x;
                if ($signed(pt.y) > $signed(box_reg.high.y)) box_next.high.y = pt.y;
                if ($signed(pt.z) > $signed(box_reg.high.z)) box_next.high.z = pt.z;
                if (cnt_reg < BATCH_CNT) begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            closed_next = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_reg.low  <= '{pbq_pkg::COORD_MAX, pbq_pkg::COORD_MAX, pbq_pkg::COORD_MAX};
            box_reg.high <= '{pbq_pkg::COORD_MIN, pbq_pkg::COORD_MIN, pbq_pkg::COORD_MIN};
            cnt_reg      <= '0;
            closed_reg   <= 1'b1;
        end else begin
            box_reg    <= box_next;
            cnt_reg    <= cnt_next;
            closed_reg <= closed_next;
        end
    end

    assign cnt_wide = {{pbq_pkg::TOTAL_W{1'b0}}, cnt_reg};
    assign box      = box_reg;
    assign total    = cnt_wide[pbq_pkg::TOTAL_W-1:0];

endmodule
`default_nettype wire

@@ hw/rtl/pbq_div.sv @@
// Bit-serial restoring divider for one axis: code = floor((v-lo)*2^30/(hi-lo)).
// One quotient bit per step; depends on pbq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbq_div (
    input  wire logic                            aclk,
    input  wire logic                            load,
    input  wire logic                            prep,
    input  wire logic                            step,
    input  wire pbq_pkg::coord_t                 v,
    input  wire pbq_pkg::coord_t                 lo,
    input  wire pbq_pkg::coord_t                 hi,
    output logic [pbq_pkg::CODE_BITS-1:0]        code
);

    localparam int W = pbq_pkg::COORD_W;

    logic [W:0]                      dif, span;
    logic [W-1:0]                    rem_reg, rem_next;
    logic [W-1:0]                    span_reg;
    logic                            sneg_reg, dneg_reg;
    logic                            zero_reg, sat_reg;
    logic [pbq_pkg::CODE_BITS-1:0]   quo_reg;
    logic [W:0]                      r2, r2_sub;
    logic                            ge;

    assign dif  = {v[W-1], v} - {lo[W-1], lo};
    assign span = {hi[W-1], hi} - {lo[W-1], lo};

    assign r2     = {rem_reg, 1'b0};
    assign r2_sub = r2 - {1'b0, span_reg};
    assign ge     = (r2 >= {1'b0, span_reg});
    assign rem_next = ge ? r2_sub[W-1:0] : r2[W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            rem_reg  <= dif[W-1:0];
            span_reg <= span[W-1:0];
            sneg_reg <= span[W];
            dneg_reg <= dif[W];
        end else if (prep) begin
            // empty or inverted span and below-range values code as zero;
            // at or above the top of the range the code saturates
            zero_reg <= sneg_reg || (span_reg == '0) || dneg_reg;
            sat_reg  <= (rem_reg >= span_reg);
        end else if (step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[pbq_pkg::CODE_BITS-2:0], ge};
        end
    end

    always_comb begin
        if (zero_reg) begin
            code = '0;
        end else if (sat_reg) begin
            code = pbq_pkg::CODE_MAX;
        end else begin
            code = quo_reg;
        end
    end

endmodule
`default_nettype wire
